// ===== sv/b2n_pkg.sv =====
// Shared types and constants of the BGRA to NV12 converter.
package b2n_pkg;

    // Configuration register file
    localparam int CFG_W = 13;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One pixel, alpha dropped
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Horizontal pair sums kept in the line store
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } pair_sum_t;

    // Per-request control flags from front to back
    typedef struct packed {
        logic chroma;
        logic frame_end;
    } item_flags_t;

    // BT.709 limited-range coefficients, 8 fractional bits
    localparam int LUMA_R      = 47;
    localparam int LUMA_G      = 157;
    localparam int LUMA_B      = 16;
    localparam int LUMA_BIAS   = 16;
    localparam int CB_R        = -26;
    localparam int CB_G        = -87;
    localparam int CB_B        = 112;
    localparam int CR_R        = 112;
    localparam int CR_G        = -102;
    localparam int CR_B        = -10;
    localparam int ROUND_HALF  = 128;
    localparam int CHROMA_BIAS = 128;
    localparam int BYTE_MAX    = 255;

endpackage

// ===== sv/b2n_front.sv =====
// Front end: raster counters, left-pixel hold, top-row line store, block averages.
module b2n_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  b2n_pkg::pixel_t                  pixel,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  eff_height,
    output logic                             push,
    input  logic                             queue_full,
    output b2n_pkg::pixel_t                  item_pixel,
    output b2n_pkg::pixel_t                  item_avg,
    output b2n_pkg::item_flags_t             item_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]     item_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]    item_row
);
    import b2n_pkg::*;

    localparam int EW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EH_W       = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pixel_t           left_reg, left_next;

    logic             s1_valid_reg, s1_valid_next;
    pixel_t           s1_pixel_reg;
    pair_sum_t        s1_pair_reg;
    item_flags_t      s1_flags_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    pair_sum_t        line_mem [LINE_DEPTH];
    pair_sum_t        top_rd_reg;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic             odd_col;
    logic             odd_row;
    logic [IDX_W-1:0] line_idx;
    logic             line_wr;
    logic             line_rd;
    pair_sum_t        pair;
    item_flags_t      flags;

    // Handshake: hold off while stage one cannot drain into the queue
    assign pixel_stall = s1_valid_reg && queue_full;
    assign accept      = pixel_valid && !pixel_stall;
    assign push        = s1_valid_reg && !queue_full;

    // Position decode
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign last_col = EW_W'(col_reg) >= (eff_width - EW_W'(1));
    assign last_row = EH_W'(row_reg) >= (eff_height - EH_W'(1));
    assign line_idx = IDX_W'(col_reg >> 1);
    assign line_wr  = accept && odd_col && !odd_row && ((col_reg >> 1) < LINE_DEPTH);
    assign line_rd  = accept && odd_col && odd_row;

    // Horizontal pair sums with the held left pixel
    assign pair.red   = 9'(left_reg.red)   + 9'(pixel.red);
    assign pair.green = 9'(left_reg.green) + 9'(pixel.green);
    assign pair.blue  = 9'(left_reg.blue)  + 9'(pixel.blue);

    assign flags.chroma    = odd_col && odd_row;
    assign flags.frame_end = last_col && last_row;

    // Counter and hold next values
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            if (!odd_col)
            begin
                left_next = pixel;
            end
        end
    end

    // Stage one occupancy
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            left_reg     <= left_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_pair_reg  <= pair;
            s1_flags_reg <= flags;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

    // Line store: top-row pair sums, written on even rows, read on odd rows
    always_ff @(posedge clk)
    begin
        if (line_wr)
        begin
            line_mem[line_idx] <= pair;
        end
        if (line_rd)
        begin
            top_rd_reg <= line_mem[line_idx];
        end
    end

    // Block averages, floor of sum over four
    assign item_avg.red   = 8'((10'(s1_pair_reg.red)   + 10'(top_rd_reg.red))   >> 2);
    assign item_avg.green = 8'((10'(s1_pair_reg.green) + 10'(top_rd_reg.green)) >> 2);
    assign item_avg.blue  = 8'((10'(s1_pair_reg.blue)  + 10'(top_rd_reg.blue))  >> 2);

    assign item_pixel = s1_pixel_reg;
    assign item_flags = s1_flags_reg;
    assign item_col   = s1_col_reg;
    assign item_row   = s1_row_reg;

endmodule

// ===== sv/b2n_queue.sv =====
// Small FIFO between the front end and the color math back end.
module b2n_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import b2n_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/b2n_back.sv =====
// Back end: luma and chroma math, buffer offsets, output register.
module b2n_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             pop,
    input  logic                             queue_empty,
    input  b2n_pkg::pixel_t                  item_pixel,
    input  b2n_pkg::pixel_t                  item_avg,
    input  b2n_pkg::item_flags_t             item_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]     item_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]    item_row,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  eff_height,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [7:0]                       luma,
    output logic [23:0]                      luma_offset,
    output logic                             chroma_valid,
    output logic [7:0]                       cb,
    output logic [7:0]                       cr,
    output logic [24:0]                      cbcr_offset,
    output logic                             frame_end
);
    import b2n_pkg::*;

    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PROD_W = ROW_W + EW_W;
    localparam int AREA_W = EW_W + EH_W;

    // Product stage
    logic               p_valid_reg, p_valid_next;
    logic [15:0]        p_luma_sum_reg;
    logic signed [16:0] p_cb_sum_reg;
    logic signed [16:0] p_cr_sum_reg;
    logic [PROD_W-1:0]  p_luma_prod_reg;
    logic [PROD_W-1:0]  p_chroma_prod_reg;
    logic [AREA_W-1:0]  p_area_reg;
    logic [COL_W-1:0]   p_col_reg;
    item_flags_t        p_flags_reg;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         luma_reg;
    logic [23:0]        luma_offset_reg;
    logic               chroma_valid_reg;
    logic [7:0]         cb_reg;
    logic [7:0]         cr_reg;
    logic [24:0]        cbcr_offset_reg;
    logic               frame_end_reg;

    logic               out_ready;
    logic               p_ready;
    logic               p_move;
    logic signed [16:0] ar_s;
    logic signed [16:0] ag_s;
    logic signed [16:0] ab_s;
    logic signed [16:0] cb_biased;
    logic signed [16:0] cr_biased;
    logic [COL_W-1:0]   col_even;

    function automatic logic [7:0] sat_byte(input logic signed [16:0] v);
        if (v < 0)
        begin
            return 8'd0;
        end
        else if (v > BYTE_MAX)
        begin
            return 8'(BYTE_MAX);
        end
        return v[7:0];
    endfunction

    // Pipeline flow control
    assign out_ready = !out_valid_reg || !result_stall;
    assign p_ready   = !p_valid_reg || out_ready;
    assign pop       = !queue_empty && p_ready;
    assign p_move    = p_valid_reg && out_ready;

    always_comb
    begin
        p_valid_next   = p_ready ? pop : p_valid_reg;
        out_valid_next = out_ready ? p_move : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Weighted sums and offset products
    assign ar_s = {9'd0, item_avg.red};
    assign ag_s = {9'd0, item_avg.green};
    assign ab_s = {9'd0, item_avg.blue};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_luma_sum_reg    <= 16'(LUMA_R * item_pixel.red + LUMA_G * item_pixel.green
                                     + LUMA_B * item_pixel.blue + ROUND_HALF);
            p_cb_sum_reg      <= 17'(CB_R * ar_s + CB_G * ag_s + CB_B * ab_s + ROUND_HALF);
            p_cr_sum_reg      <= 17'(CR_R * ar_s + CR_G * ag_s + CR_B * ab_s + ROUND_HALF);
            p_luma_prod_reg   <= PROD_W'(item_row) * PROD_W'(eff_width);
            p_chroma_prod_reg <= PROD_W'(item_row >> 1) * PROD_W'(eff_width);
            p_area_reg        <= AREA_W'(eff_width) * AREA_W'(eff_height);
            p_col_reg         <= item_col;
            p_flags_reg       <= item_flags;
        end
    end

    // Floor shift, bias and clamp; offset sums
    assign cb_biased = (p_cb_sum_reg >>> 8) + 17'sd128;
    assign cr_biased = (p_cr_sum_reg >>> 8) + 17'sd128;
    assign col_even  = {p_col_reg[COL_W-1:1], 1'b0};

    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            luma_reg         <= 8'(LUMA_BIAS) + p_luma_sum_reg[15:8];
            luma_offset_reg  <= 24'(p_luma_prod_reg) + 24'(p_col_reg);
            chroma_valid_reg <= p_flags_reg.chroma;
            frame_end_reg    <= p_flags_reg.frame_end;
            if (p_flags_reg.chroma)
            begin
                cb_reg          <= sat_byte(cb_biased);
                cr_reg          <= sat_byte(cr_biased);
                cbcr_offset_reg <= 25'(p_area_reg) + 25'(p_chroma_prod_reg) + 25'(col_even);
            end
            else
            begin
                cb_reg          <= '0;
                cr_reg          <= '0;
                cbcr_offset_reg <= '0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign luma         = luma_reg;
    assign luma_offset  = luma_offset_reg;
    assign chroma_valid = chroma_valid_reg;
    assign cb           = cb_reg;
    assign cr           = cr_reg;
    assign cbcr_offset  = cbcr_offset_reg;
    assign frame_end    = frame_end_reg;

endmodule

// ===== sv/bgra_to_nv12_convert.sv =====
// Top level of the BGRA to NV12 converter: configuration registers and the three stages.
//
//   channel   handshake                   payload
//   pixel     pixel_valid / pixel_stall   blue, green, red
//   result    result_valid / result_stall luma, luma_offset, chroma_valid, cb, cr,
//                                         cbcr_offset, frame_end
//   config    cfg_write                   cfg_index, cfg_data
//
// One pixel per clock, sustained while results are not stalled; a result passes through the
// front stage with its line store read, the queue, the product stage, the output register.
// Reset clears counters, the left-pixel hold and all valids; line store entries start
// undefined and are only read after the top row of the block pair wrote them.
// A stalled result backs up through the four-entry queue; pixels stall only once it is full.
module bgra_to_nv12_convert #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [0:0]                 cfg_index,
    input  logic [b2n_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       pixel_valid,
    output logic                       pixel_stall,
    input  logic [7:0]                 blue,
    input  logic [7:0]                 green,
    input  logic [7:0]                 red,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [7:0]                 luma,
    output logic [23:0]                luma_offset,
    output logic                       chroma_valid,
    output logic [7:0]                 cb,
    output logic [7:0]                 cr,
    output logic [24:0]                cbcr_offset,
    output logic                       frame_end
);
    import b2n_pkg::*;

    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ITEM_W = 2 * $bits(pixel_t) + $bits(item_flags_t) + COL_W + ROW_W;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [CFG_W-1:0] width_even;
    logic [CFG_W-1:0] height_even;
    logic [EW_W-1:0]  eff_width;
    logic [EH_W-1:0]  eff_height;

    pixel_t           pixel;
    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_empty;
    pixel_t           f_pixel;
    pixel_t           f_avg;
    item_flags_t      f_flags;
    logic [COL_W-1:0] f_col;
    logic [ROW_W-1:0] f_row;
    pixel_t           b_pixel;
    pixel_t           b_avg;
    item_flags_t      b_flags;
    logic [COL_W-1:0] b_col;
    logic [ROW_W-1:0] b_row;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
            endcase
        end
    end

    // Effective frame size: even, saturated to 2..max
    assign width_even  = {frame_width_reg[CFG_W-1:1], 1'b0};
    assign height_even = {frame_height_reg[CFG_W-1:1], 1'b0};

    always_comb
    begin
        if (width_even < CFG_W'(2))
        begin
            eff_width = EW_W'(2);
        end
        else if (width_even > MAX_WIDTH)
        begin
            eff_width = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW_W'(width_even);
        end

        if (height_even < CFG_W'(2))
        begin
            eff_height = EH_W'(2);
        end
        else if (height_even > MAX_HEIGHT)
        begin
            eff_height = EH_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_height = EH_W'(height_even);
        end
    end

    assign pixel.red   = red;
    assign pixel.green = green;
    assign pixel.blue  = blue;

    b2n_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .push        (push),
        .queue_full  (queue_full),
        .item_pixel  (f_pixel),
        .item_avg    (f_avg),
        .item_flags  (f_flags),
        .item_col    (f_col),
        .item_row    (f_row)
    );

    b2n_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({f_pixel, f_avg, f_flags, f_col, f_row}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  ({b_pixel, b_avg, b_flags, b_col, b_row}),
        .empty     (queue_empty)
    );

    b2n_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .queue_empty  (queue_empty),
        .item_pixel   (b_pixel),
        .item_avg     (b_avg),
        .item_flags   (b_flags),
        .item_col     (b_col),
        .item_row     (b_row),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .luma         (luma),
        .luma_offset  (luma_offset),
        .chroma_valid (chroma_valid),
        .cb           (cb),
        .cr           (cr),
        .cbcr_offset  (cbcr_offset),
        .frame_end    (frame_end)
    );

endmodule
